FILE: rtl/atc_pkg.sv
package atc_pkg;

	localparam int NUM_CHANNELS_DEF = 128;

	localparam int CH_W      = 7;
	localparam int DATA_W    = 16;
	localparam int SLOPE_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = DATA_W + SLOPE_W;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] ADDR_ENABLE = 3'd0;

	localparam logic MODE_READ = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam logic [DATA_W-1:0] SEG_MID = 16'h0200;
	localparam logic [DATA_W-1:0] SEG_TOP = 16'h03ff;
	localparam logic [DATA_W-1:0] SAT_MAX = 16'h7fff;

	typedef struct packed {
		logic signed [DATA_W-1:0] low_start;
		logic signed [DATA_W-1:0] low_end;
		logic signed [DATA_W-1:0] high_start;
		logic signed [DATA_W-1:0] high_end;
		logic [SLOPE_W-1:0]       low_slope;
		logic [SLOPE_W-1:0]       high_slope;
	} curve_t;

	typedef enum logic [2:0] {
		SG_ZERO,
		SG_LOW,
		SG_MID,
		SG_TOP,
		SG_HIGH
	} seg_t;

endpackage

FILE: rtl/aftertouch_curve_calibrator.sv
// Per-channel two-segment aftertouch calibrator. The next item is taken while
// the last one writes back, when the result side keeps up: the accept edge
// issues the reads of the curve and last-value RAMs, the next cycle selects
// the segment and runs the 16x32 slope multiply, and the cycle after that
// saturates, compares against the cached value and writes the cache back while
// the next beat is taken. That read-modify-write of the cache RAM paces the
// items; a write that meets the read of the following beat on the same channel
// is forwarded. A load beat writes the curve entry and clears the cache entry
// and gives no result. A finished result waits in an output register, and a
// reading beat stalls in its last cycle only while that register is still full.
// Channels at or above NUM_CHANNELS pass the raw value through and change
// nothing. Reading a channel that was never loaded with calibration enabled
// returns unspecified data.
module aftertouch_curve_calibrator #(
	parameter int NUM_CHANNELS = atc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [atc_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [atc_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [atc_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                mode,
	input  logic [atc_pkg::CH_W-1:0]            channel,
	input  logic signed [atc_pkg::DATA_W-1:0]   raw_reading,
	input  logic signed [atc_pkg::DATA_W-1:0]   low_start,
	input  logic signed [atc_pkg::DATA_W-1:0]   low_end,
	input  logic signed [atc_pkg::DATA_W-1:0]   high_start,
	input  logic signed [atc_pkg::DATA_W-1:0]   high_end,
	input  logic [atc_pkg::SLOPE_W-1:0]         low_slope,
	input  logic [atc_pkg::SLOPE_W-1:0]         high_slope,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [atc_pkg::DATA_W-1:0]   calibrated_value,
	output logic                                unchanged,
	output logic [atc_pkg::CH_W-1:0]            result_channel
);
	import atc_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic cal_en;

	logic                 item_accept;
	logic [AW+CH_W-1:0]   ch_wide;
	logic [AW-1:0]        rd_addr;
	logic                 in_range;

	logic                 mode_s1;
	logic [CH_W-1:0]      ch_s1;
	logic [AW-1:0]        addr_s1;
	logic                 in_range_s1;
	logic signed [DATA_W-1:0] raw_s1;
	curve_t               load_s1;

	curve_t               curve_rd;
	logic [DATA_W-1:0]    cache_rd;
	curve_t               entry_sel;
	logic [DATA_W-1:0]    cache_sel;

	logic                 fwd_curve_q;
	logic                 fwd_cache_q;
	curve_t               fwd_entry_q;
	logic [DATA_W-1:0]    fwd_value_q;

	logic [DATA_W-1:0]    map_value;
	logic                 map_same;

	logic                 is_load;
	logic                 passthru;
	logic                 go;
	logic                 done_go;
	logic                 curve_we;
	logic                 cache_we;
	logic [DATA_W-1:0]    cache_wd;

	logic                 result_valid_q;
	logic [DATA_W-1:0]    result_value_q;
	logic                 result_same_q;
	logic [CH_W-1:0]      result_ch_q;

	atc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal_en  (cal_en)
	);

	assign ch_wide  = {{AW{1'b0}}, channel};
	assign rd_addr  = ch_wide[AW-1:0];
	assign in_range = 32'(channel) < 32'(NUM_CHANNELS);

	assign is_load  = (mode_s1 == MODE_LOAD);
	assign passthru = !cal_en || !in_range_s1;
	assign go       = is_load || !result_valid_q || result_ready;
	assign done_go  = (state_q == ST_DONE) && go;

	assign item_ready  = (state_q == ST_IDLE) || done_go;
	assign item_accept = item_valid && item_ready;

	assign curve_we = done_go && is_load && in_range_s1;
	assign cache_we = done_go && in_range_s1 && (is_load || (cal_en && !map_same));
	assign cache_wd = is_load ? '0 : map_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: state_q <= ST_DONE;
				ST_DONE: begin
					if (item_accept) begin
						state_q <= ST_CALC;
					end else if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			mode_s1             <= mode;
			ch_s1               <= channel;
			addr_s1             <= rd_addr;
			in_range_s1         <= in_range;
			raw_s1              <= raw_reading;
			load_s1.low_start   <= low_start;
			load_s1.low_end     <= low_end;
			load_s1.high_start  <= high_start;
			load_s1.high_end    <= high_end;
			load_s1.low_slope   <= low_slope;
			load_s1.high_slope  <= high_slope;
		end
	end

	// writeback of the finishing beat lands on the same edge as the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_curve_q <= 1'b0;
			fwd_cache_q <= 1'b0;
		end else if (item_accept) begin
			fwd_curve_q <= curve_we && (addr_s1 == rd_addr);
			fwd_cache_q <= cache_we && (addr_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			fwd_entry_q <= load_s1;
			fwd_value_q <= cache_wd;
		end
	end

	atc_ram #(
		.WIDTH ($bits(curve_t)),
		.DEPTH (NUM_CHANNELS)
	) u_curve_ram (
		.clk   (clk),
		.we    (curve_we),
		.waddr (addr_s1),
		.wdata (load_s1),
		.re    (item_accept),
		.raddr (rd_addr),
		.rdata (curve_rd)
	);

	atc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (NUM_CHANNELS)
	) u_cache_ram (
		.clk   (clk),
		.we    (cache_we),
		.waddr (addr_s1),
		.wdata (cache_wd),
		.re    (item_accept),
		.raddr (rd_addr),
		.rdata (cache_rd)
	);

	assign entry_sel = fwd_curve_q ? fwd_entry_q : curve_rd;
	assign cache_sel = fwd_cache_q ? fwd_value_q : cache_rd;

	atc_map u_map (
		.clk   (clk),
		.calc  (state_q == ST_CALC),
		.raw   (raw_s1),
		.entry (entry_sel),
		.cache (cache_sel),
		.value (map_value),
		.same  (map_same)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done_go && !is_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go && !is_load) begin
			result_value_q <= passthru ? raw_s1 : map_value;
			result_same_q  <= passthru ? 1'b0 : map_same;
			result_ch_q    <= ch_s1;
		end
	end

	assign result_valid     = result_valid_q;
	assign calibrated_value = result_value_q;
	assign unchanged        = result_same_q;
	assign result_channel   = result_ch_q;

	a_no_accept_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !item_ready)
		else $error("beat accepted while the multiply stage is busy");

	a_calc_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |=> (state_q == ST_DONE))
		else $error("multiply stage not followed by writeback");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside writeback");

	a_cache_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(item_accept && cache_we && (addr_s1 == rd_addr)) |=> fwd_cache_q)
		else $error("cache writeback to the next beat's channel not forwarded");

endmodule

FILE: rtl/atc_ram.sv
module atc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/atc_cfg.sv
module atc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [atc_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [atc_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [atc_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic                             cal_en
);
	import atc_pkg::*;

	logic en_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready & (paddr == ADDR_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (wr_en) begin
			en_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == ADDR_ENABLE) ? {{(CFG_DATA_W-1){1'b0}}, en_q} : '0;
	assign cal_en = en_q;

endmodule

FILE: rtl/atc_map.sv
module atc_map (
	input  logic                               clk,
	input  logic                               calc,
	input  logic signed [atc_pkg::DATA_W-1:0]  raw,
	input  atc_pkg::curve_t                    entry,
	input  logic [atc_pkg::DATA_W-1:0]         cache,
	output logic [atc_pkg::DATA_W-1:0]         value,
	output logic                               same
);
	import atc_pkg::*;

	seg_t               seg_c;
	seg_t               seg_s2;
	logic [DATA_W:0]    diff_lo;
	logic [DATA_W:0]    diff_hi;
	logic [DATA_W-1:0]  mul_d;
	logic [SLOPE_W-1:0] mul_s;
	logic [PROD_W-1:0]  prod_c;
	logic [PROD_W-1:0]  prod_s2;
	logic [DATA_W-1:0]  cache_s2;
	logic [SLOPE_W:0]   sum;
	logic [DATA_W-1:0]  sat_val;

	// segment decision, taken in the same order as the curve definition
	always_comb begin
		if (raw < entry.low_start) begin
			seg_c = SG_ZERO;
		end else if (raw < entry.low_end) begin
			seg_c = SG_LOW;
		end else if (raw <= entry.high_start) begin
			seg_c = SG_MID;
		end else if (raw > entry.high_end) begin
			seg_c = SG_TOP;
		end else begin
			seg_c = SG_HIGH;
		end
	end

	// difference is non-negative inside either sloped segment
	assign diff_lo = {raw[DATA_W-1], raw} - {entry.low_start[DATA_W-1], entry.low_start};
	assign diff_hi = {raw[DATA_W-1], raw} - {entry.high_start[DATA_W-1], entry.high_start};

	always_comb begin
		if (seg_c == SG_LOW) begin
			mul_d = diff_lo[DATA_W-1:0];
			mul_s = entry.low_slope;
		end else begin
			mul_d = diff_hi[DATA_W-1:0];
			mul_s = entry.high_slope;
		end
	end

	assign prod_c = PROD_W'(mul_d) * PROD_W'(mul_s);

	always_ff @(posedge clk) begin
		if (calc) begin
			seg_s2   <= seg_c;
			prod_s2  <= prod_c;
			cache_s2 <= cache;
		end
	end

	// drop the q16 fraction, add the mid offset, clamp
	assign sum = {1'b0, prod_s2[PROD_W-1:FRAC_BITS]}
		+ ((seg_s2 == SG_HIGH) ? (SLOPE_W+1)'(SEG_MID) : '0);
	assign sat_val = (sum > (SLOPE_W+1)'(SAT_MAX)) ? SAT_MAX : sum[DATA_W-1:0];

	always_comb begin
		case (seg_s2)
			SG_ZERO: value = '0;
			SG_LOW:  value = sat_val;
			SG_MID:  value = SEG_MID;
			SG_TOP:  value = SEG_TOP;
			SG_HIGH: value = sat_val;
			default: value = '0;
		endcase
	end

	assign same = (cache_s2 == value);

endmodule
